// ===== rtl/core/bbmt_pkg.sv =====
// Package for the bounding box merge table: sizes, coordinate and rectangle
// types, function codes and the sequencer states.
// Depends on nothing; used by bbmt_merge_unit and the top level.
package bbmt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int COORD_BITS  = 12;
   localparam int MARGIN_BITS = 6;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam int EXT_BITS    = COORD_BITS + 3;

   localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = MARGIN_BITS'(5);
   localparam logic [COORD_BITS-1:0]  COORD_MAX    = '1;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_FLUSH  = 1'b1;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic signed [EXT_BITS-1:0] ecoord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type w;
      coord_type h;
   } rect_type;

   typedef struct packed {
      ecoord_type x0;
      ecoord_type y0;
      ecoord_type x1;
      ecoord_type y1;
   } span_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_FLUSH_RD,
      ST_FLUSH_OUT,
      ST_EMPTY
   } state_type;

   function automatic ecoord_type ext(input coord_type v);
      return ecoord_type'({{(EXT_BITS-COORD_BITS){1'b0}}, v});
   endfunction

endpackage

// ===== rtl/core/bbmt_merge_unit.sv =====
// Shared overlap test and bounding-box union for one stored rectangle.
// Depends on bbmt_pkg; the top level sequencer has one instance and shares it across all table entries.
module bbmt_merge_unit (
   input  bbmt_pkg::span_type grown,
   input  bbmt_pkg::rect_type stored,
   input  bbmt_pkg::span_type acc,
   output logic               hit,
   output bbmt_pkg::span_type merged
);
   import bbmt_pkg::*;

   ecoord_type sx0;
   ecoord_type sy0;
   ecoord_type sx1;
   ecoord_type sy1;
   ecoord_type lo_x;
   ecoord_type hi_x;
   ecoord_type lo_y;
   ecoord_type hi_y;

   always_comb begin
      sx0  = ext(stored.x);
      sy0  = ext(stored.y);
      sx1  = sx0 + ext(stored.w);
      sy1  = sy0 + ext(stored.h);
      lo_x = (grown.x0 > sx0) ? grown.x0 : sx0;
      hi_x = (grown.x1 < sx1) ? grown.x1 : sx1;
      lo_y = (grown.y0 > sy0) ? grown.y0 : sy0;
      hi_y = (grown.y1 < sy1) ? grown.y1 : sy1;
      hit  = (lo_x < hi_x) && (lo_y < hi_y);
      merged.x0 = (sx0 < acc.x0) ? sx0 : acc.x0;
      merged.y0 = (sy0 < acc.y0) ? sy0 : acc.y0;
      merged.x1 = (sx1 > acc.x1) ? sx1 : acc.x1;
      merged.y1 = (sy1 > acc.y1) ? sy1 : acc.y1;
   end

endmodule

// ===== rtl/core/bounding_box_merge_table_top.sv =====
// Bounding box merge table: an insert grows the new rectangle by the margin,
// walks the stored entries one per cycle through a shared merge unit, folds
// every entry that overlaps the grown rectangle into the new one while
// compacting the survivors in place, and appends the merged rectangle unless
// the survivors fill the table, which gives an overflow beat; a flush emits
// all entries in order and empties the table. The entry memory has a single
// read port; a flush reads each entry and then emits it. Each input beat
// gives one result beat, except a flush of a non-empty table, which gives
// one per entry. Depends on bbmt_pkg and bbmt_merge_unit.
module bounding_box_merge_table_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [bbmt_pkg::COORD_BITS-1:0]     req_rect_x,
   input  logic [bbmt_pkg::COORD_BITS-1:0]     req_rect_y,
   input  logic [bbmt_pkg::COORD_BITS-1:0]     req_rect_w,
   input  logic [bbmt_pkg::COORD_BITS-1:0]     req_rect_h,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bbmt_pkg::COORD_BITS-1:0]     rsp_out_x,
   output logic [bbmt_pkg::COORD_BITS-1:0]     rsp_out_y,
   output logic [bbmt_pkg::COORD_BITS-1:0]     rsp_out_w,
   output logic [bbmt_pkg::COORD_BITS-1:0]     rsp_out_h,
   output logic                                rsp_entry_valid,
   output logic [bbmt_pkg::CNT_BITS-1:0]       rsp_entry_count,
   output logic                                rsp_overflow,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bbmt_pkg::MARGIN_BITS-1:0]    csr_data
);
   import bbmt_pkg::*;

   rect_type                rect_store [TABLE_DEPTH];

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [CNT_BITS-1:0]     rd_idx_ff, rd_idx_in;
   logic [CNT_BITS-1:0]     keep_ff, keep_in;
   logic                    data_vld_ff, data_vld_in;
   span_type                grown_ff, grown_in;
   span_type                acc_ff, acc_in;
   logic [MARGIN_BITS-1:0]  margin_ff;
   rect_type                rd_data_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   rect_type                rsp_rect_ff, rsp_rect_in;
   logic                    rsp_entry_valid_ff, rsp_entry_valid_in;
   logic [CNT_BITS-1:0]     rsp_count_ff, rsp_count_in;
   logic                    rsp_overflow_ff, rsp_overflow_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    rd_en;
   logic                    wr_en;
   rect_type                wr_data;
   logic                    out_free;
   logic                    hit;
   span_type                merged;
   ecoord_type              ext_margin;
   ecoord_type              span_w;
   ecoord_type              span_h;
   rect_type                result;
   logic                    flush_last;

   bbmt_merge_unit u_merge (
      .grown  (grown_ff),
      .stored (rd_data_ff),
      .acc    (acc_ff),
      .hit    (hit),
      .merged (merged)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rect_store[keep_ff[IDX_BITS-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= rect_store[rd_idx_ff[IDX_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         keep_ff      <= '0;
         data_vld_ff  <= 1'b0;
         margin_ff    <= MARGIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         keep_ff      <= keep_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            margin_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      grown_ff           <= grown_in;
      acc_ff             <= acc_in;
      rsp_rect_ff        <= rsp_rect_in;
      rsp_entry_valid_ff <= rsp_entry_valid_in;
      rsp_count_ff       <= rsp_count_in;
      rsp_overflow_ff    <= rsp_overflow_in;
      rsp_last_ff        <= rsp_last_in;
   end

   always_comb begin
      ext_margin = ecoord_type'({{(EXT_BITS-MARGIN_BITS){1'b0}}, margin_ff});
      span_w     = acc_ff.x1 - acc_ff.x0;
      span_h     = acc_ff.y1 - acc_ff.y0;
      result.x   = acc_ff.x0[COORD_BITS-1:0];
      result.y   = acc_ff.y0[COORD_BITS-1:0];
      result.w   = (span_w > ext(COORD_MAX)) ? COORD_MAX : span_w[COORD_BITS-1:0];
      result.h   = (span_h > ext(COORD_MAX)) ? COORD_MAX : span_h[COORD_BITS-1:0];
      flush_last = (rd_idx_ff + CNT_BITS'(1)) == count_ff;
      out_free   = !rsp_valid_ff || !rsp_stall;

      state_in           = state_ff;
      count_in           = count_ff;
      rd_idx_in          = rd_idx_ff;
      keep_in            = keep_ff;
      data_vld_in        = data_vld_ff;
      grown_in           = grown_ff;
      acc_in             = acc_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_rect_in        = rsp_rect_ff;
      rsp_entry_valid_in = rsp_entry_valid_ff;
      rsp_count_in       = rsp_count_ff;
      rsp_overflow_in    = rsp_overflow_ff;
      rsp_last_in        = rsp_last_ff;
      rd_en              = 1'b0;
      wr_en              = 1'b0;
      wr_data            = rd_data_ff;
      req_stall          = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               rd_idx_in = '0;
               if (req_func == FUNC_FLUSH) begin
                  state_in = (count_ff == '0) ? ST_EMPTY : ST_FLUSH_RD;
               end else begin
                  acc_in.x0   = ext(req_rect_x);
                  acc_in.y0   = ext(req_rect_y);
                  acc_in.x1   = ext(req_rect_x) + ext(req_rect_w);
                  acc_in.y1   = ext(req_rect_y) + ext(req_rect_h);
                  grown_in.x0 = ext(req_rect_x) - ext_margin;
                  grown_in.y0 = ext(req_rect_y) - ext_margin;
                  grown_in.x1 = acc_in.x1 + ext_margin;
                  grown_in.y1 = acc_in.y1 + ext_margin;
                  keep_in     = '0;
                  data_vld_in = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            data_vld_in = 1'b0;
            if (rd_idx_ff != count_ff) begin
               rd_en       = 1'b1;
               rd_idx_in   = rd_idx_ff + CNT_BITS'(1);
               data_vld_in = 1'b1;
            end
            if (data_vld_ff) begin
               if (hit) begin
                  acc_in = merged;
               end else begin
                  wr_en   = 1'b1;
                  keep_in = keep_ff + CNT_BITS'(1);
               end
            end else if (rd_idx_ff == count_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (keep_ff == CNT_BITS'(TABLE_DEPTH)) begin
                  rsp_rect_in        = '0;
                  rsp_entry_valid_in = 1'b0;
                  rsp_count_in       = count_ff;
                  rsp_overflow_in    = 1'b1;
               end else begin
                  wr_en              = 1'b1;
                  wr_data            = result;
                  count_in           = keep_ff + CNT_BITS'(1);
                  rsp_rect_in        = result;
                  rsp_entry_valid_in = 1'b1;
                  rsp_count_in       = keep_ff + CNT_BITS'(1);
                  rsp_overflow_in    = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH_RD: begin
            rd_en    = 1'b1;
            state_in = ST_FLUSH_OUT;
         end
         ST_FLUSH_OUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_rect_in        = rd_data_ff;
               rsp_entry_valid_in = 1'b1;
               rsp_count_in       = '0;
               rsp_overflow_in    = 1'b0;
               rsp_last_in        = flush_last;
               if (flush_last) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + CNT_BITS'(1);
                  state_in  = ST_FLUSH_RD;
               end
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_rect_in        = '0;
               rsp_entry_valid_in = 1'b0;
               rsp_count_in       = '0;
               rsp_overflow_in    = 1'b0;
               rsp_last_in        = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = rsp_rect_ff.x;
   assign rsp_out_y       = rsp_rect_ff.y;
   assign rsp_out_w       = rsp_rect_ff.w;
   assign rsp_out_h       = rsp_rect_ff.h;
   assign rsp_entry_valid = rsp_entry_valid_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_overflow    = rsp_overflow_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(TABLE_DEPTH))
      else $error("Table count exceeds the table depth.");

   a_compact_order : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (keep_ff <= rd_idx_ff) && (rd_idx_ff <= count_ff))
      else $error("Compaction write index overtook the read index.");

   a_overflow_beat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_overflow_ff |-> !rsp_entry_valid_ff && rsp_last_ff)
      else $error("Overflow beat carries an entry or is not the last beat.");

   a_flush_clears : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && $past(state_ff) == ST_FLUSH_OUT |-> count_ff == '0)
      else $error("Table not empty after a flush.");
`endif

endmodule
